// ===== design/assert_macros.svh =====
// Assertion helpers included by the top-level classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check that is off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== design/xbic_pkg.sv =====
package xbic_pkg;

    // Field widths of one item and one result.
    localparam int LOW_W    = 64;
    localparam int HIGH_W   = 56;
    localparam int LEN_W    = 4;
    localparam int ADDR_W   = 32;
    localparam int CLASS_W  = 4;
    localparam int FORM_W   = 3;
    localparam int STATUS_W = 2;

    // Bytes carried by one item, and the longest legal instruction.
    localparam int IN_BYTES        = (LOW_W + HIGH_W) / 8;
    localparam int MAX_INSTR_BYTES = 15;

    // Byte window seen by the decoder: the item bytes plus zero padding, so that
    // the opcode and the five bytes after it can be read at any prefix count.
    localparam int IDX_W     = 5;
    localparam int PAD_BYTES = 1 << IDX_W;

    // Image base after reset.
    localparam logic [ADDR_W-1:0] IMAGE_BASE_RESET = 32'h0040_0000;

    // Opcodes with a role of their own.
    localparam logic [7:0] OP_LOCK     = 8'hF0;
    localparam logic [7:0] OP_OPSIZE   = 8'h66;
    localparam logic [7:0] OP_ADSIZE   = 8'h67;
    localparam logic [7:0] OP_NOP      = 8'h90;
    localparam logic [7:0] OP_TWO_BYTE = 8'h0F;
    localparam logic [7:0] OP_GRP5     = 8'hFF;
    localparam logic [7:0] OP_CALL_REL = 8'hE8;
    localparam logic [7:0] OP_JMP_REL  = 8'hE9;
    localparam logic [7:0] OP_JMP_FAR  = 8'hEA;
    localparam logic [7:0] OP_JMP_SH   = 8'hEB;
    localparam logic [7:0] OP_CALL_FAR = 8'h9A;
    localparam logic [7:0] OP_RET      = 8'hC3;
    localparam logic [7:0] OP_LEA      = 8'h8D;
    localparam logic [7:0] OP_JCC_LO   = 8'h70;
    localparam logic [7:0] OP_JCC_HI   = 8'h7F;
    localparam logic [7:0] OP_LOOP_LO  = 8'hE0;
    localparam logic [7:0] OP_LOOP_HI  = 8'hE3;
    localparam logic [7:0] OP_JCC32_LO = 8'h80;
    localparam logic [7:0] OP_JCC32_HI = 8'h8F;

    // ModRM reg field values of the FF group.
    localparam logic [2:0] REG_CALL_N = 3'd2;
    localparam logic [2:0] REG_CALL_F = 3'd3;
    localparam logic [2:0] REG_JMP_N  = 3'd4;
    localparam logic [2:0] REG_JMP_F  = 3'd5;
    localparam logic [2:0] REG_PUSH   = 3'd6;

    // ModRM form of an absolute disp32 memory operand.
    localparam logic [1:0] MOD_MEM   = 2'd0;
    localparam logic [2:0] RM_DISP32 = 3'd5;

    typedef enum logic [CLASS_W-1:0] {
        CLS_OTHER      = 4'd0,
        CLS_NOP        = 4'd1,
        CLS_CONDJUMP   = 4'd2,
        CLS_UNCONDJUMP = 4'd3,
        CLS_CALL       = 4'd4,
        CLS_RET        = 4'd5,
        CLS_INTERRUPT  = 4'd6,
        CLS_X87        = 4'd7,
        CLS_STACK      = 4'd8
    } t_instr_class;

    typedef enum logic [FORM_W-1:0] {
        FORM_NONE  = 3'd0,
        FORM_EBGB  = 3'd1,
        FORM_GBEB  = 3'd2,
        FORM_EVGV  = 3'd3,
        FORM_GVEV  = 3'd4,
        FORM_GVM   = 3'd5,
        FORM_OTHER = 3'd6
    } t_form;

    typedef enum logic [STATUS_W-1:0] {
        ST_RESOLVED    = 2'd0,
        ST_NOT_BRANCH  = 2'd1,
        ST_REG_INDIR   = 2'd2,
        ST_UNSUPPORTED = 2'd3
    } t_status;

    // One input item.
    typedef struct packed {
        logic [LOW_W-1:0]  bytes_low;
        logic [HIGH_W-1:0] bytes_high;
        logic [LEN_W-1:0]  length;
        logic [ADDR_W-1:0] instr_addr;
    } t_item;

    // One result item.
    typedef struct packed {
        t_instr_class      instr_class;
        t_form             operand_form;
        logic [ADDR_W-1:0] branch_target;
        t_status           target_status;
        logic [LEN_W-1:0]  prefix_count;
    } t_result;

endpackage

// ===== design/xbic_decode.sv =====
module xbic_decode (
    input  xbic_pkg::t_item                 i_item,
    input  logic [xbic_pkg::ADDR_W-1:0]     i_image_base,
    output xbic_pkg::t_result               o_result
);
    import xbic_pkg::*;

    // Legacy prefix bytes.
    function automatic logic is_prefix(input logic [7:0] b);
        return b == OP_LOCK || b == 8'hF2 || b == 8'hF3 || b == OP_OPSIZE ||
               b == OP_ADSIZE || b == 8'h2E || b == 8'h36 || b == 8'h3E ||
               b == 8'h26 || b == 8'h64 || b == 8'h65;
    endfunction

    // Instruction class from the opcode and the byte after it.
    function automatic t_instr_class classify(input logic [7:0] op, input logic [7:0] b1);
        logic [2:0] rg;
        rg = b1[5:3];
        if (op == OP_NOP)
            return CLS_NOP;
        if ((op >= OP_JCC_LO && op <= OP_JCC_HI) || (op >= OP_LOOP_LO && op <= OP_LOOP_HI) ||
            (op == OP_TWO_BYTE && b1 >= OP_JCC32_LO && b1 <= OP_JCC32_HI))
            return CLS_CONDJUMP;
        if ((op >= OP_JMP_REL && op <= OP_JMP_SH) ||
            (op == OP_GRP5 && (rg == REG_JMP_N || rg == REG_JMP_F)))
            return CLS_UNCONDJUMP;
        if (op == OP_CALL_FAR || op == OP_CALL_REL ||
            (op == OP_GRP5 && (rg == REG_CALL_N || rg == REG_CALL_F)))
            return CLS_CALL;
        if (op == 8'hC2 || op == OP_RET || op == 8'hCA || op == 8'hCB || op == 8'hCF)
            return CLS_RET;
        if ((op >= 8'hCC && op <= 8'hCE) || op == 8'hF1)
            return CLS_INTERRUPT;
        if (op == 8'h9B || (op >= 8'hD8 && op <= 8'hDF) || (op == OP_TWO_BYTE && b1 == 8'h77))
            return CLS_X87;
        if (op == 8'h06 || op == 8'h07 || op == 8'h0E || op == 8'h16 || op == 8'h17 ||
            op == 8'h1E || op == 8'h1F || (op >= 8'h50 && op <= 8'h62) || op == 8'h68 ||
            op == 8'h6A || op == 8'h8F || op == 8'h9C || op == 8'h9D || op == 8'hC8 ||
            op == 8'hC9 || (op == OP_GRP5 && rg == REG_PUSH) ||
            (op == OP_TWO_BYTE &&
             (b1 == 8'hA0 || b1 == 8'hA1 || b1 == 8'hA8 || b1 == 8'hA9)))
            return CLS_STACK;
        return CLS_OTHER;
    endfunction

    // ModRM operand form of the primary opcode.
    function automatic t_form form_of(input logic [7:0] op);
        if (op == 8'h06 || op == 8'h07 || op == 8'h0E || op == 8'h16 || op == 8'h17 ||
            op == 8'h1E || op == 8'h1F || op == 8'h27 || op == 8'h2F || op == 8'h37 ||
            op == 8'h3F || (op >= 8'h40 && op <= 8'h61) || (op >= 8'h6C && op <= 8'h6F) ||
            (op >= 8'h90 && op <= 8'h99) || (op >= 8'h9B && op <= 8'h9F) ||
            (op >= 8'hA4 && op <= 8'hA7) || (op >= 8'hAA && op <= 8'hAF) || op == OP_RET ||
            op == 8'hC9 || op == 8'hCB || op == 8'hCC || op == 8'hCE || op == 8'hCF ||
            op == 8'hD7 || (op >= 8'hEC && op <= 8'hEF) || op == 8'hF4 || op == 8'hF5 ||
            (op >= 8'hF8 && op <= 8'hFD))
            return FORM_NONE;
        if ((op <= 8'h38 && op[2:0] == 3'd0) || op == 8'h88 || op == 8'h84)
            return FORM_EBGB;
        if ((op <= 8'h3A && op[2:0] == 3'd2) || op == 8'h8A || op == 8'h86)
            return FORM_GBEB;
        if ((op <= 8'h39 && op[2:0] == 3'd1) || op == 8'h85 || op == 8'h89)
            return FORM_EVGV;
        if ((op <= 8'h3B && op[2:0] == 3'd3) || op == 8'h87 || op == 8'h8B)
            return FORM_GVEV;
        if (op == OP_LEA)
            return FORM_GVM;
        return FORM_OTHER;
    endfunction

    logic [LEN_W-1:0]          w_eff_len;
    logic [8*IN_BYTES-1:0]     w_raw;
    logic [7:0]                w_byte [PAD_BYTES];
    logic [IN_BYTES-1:0]       w_pfx;
    logic [IN_BYTES-1:0]       w_ovr;
    logic [LEN_W-1:0]          w_pc;
    logic                      w_size_ovr;
    logic [7:0]                w_win [6];
    logic [ADDR_W-1:0]         w_end_addr;
    logic [ADDR_W-1:0]         w_disp1;
    logic [ADDR_W-1:0]         w_disp2;
    logic [ADDR_W-1:0]         w_rel8;
    logic [2:0]                w_reg;

    // Length clamped to the longest legal instruction.
    assign w_eff_len = (i_item.length > LEN_W'(MAX_INSTR_BYTES)) ?
                       LEN_W'(MAX_INSTR_BYTES) : i_item.length;
    assign w_raw = {i_item.bytes_high, i_item.bytes_low};

    // Byte window: bytes past the end of the instruction read as zero.
    for (genvar gi = 0; gi < PAD_BYTES; gi++) begin : g_byte
        if (gi < IN_BYTES) begin : g_in
            assign w_byte[gi] = (IDX_W'(gi) < {1'b0, w_eff_len}) ? w_raw[8*gi +: 8] : 8'h00;
            assign w_pfx[gi]  = is_prefix(w_byte[gi]);
            assign w_ovr[gi]  = (w_byte[gi] == OP_OPSIZE) || (w_byte[gi] == OP_ADSIZE);
        end else begin : g_pad
            assign w_byte[gi] = 8'h00;
        end
    end

    // Prefix count: position of the first byte that is not a prefix.
    always_comb begin
        w_pc = LEN_W'(IN_BYTES);
        for (int i = IN_BYTES - 1; i >= 0; i--) begin
            if (!w_pfx[i])
                w_pc = LEN_W'(i);
        end
    end

    // Operand or address size override among the skipped prefixes.
    always_comb begin
        w_size_ovr = 1'b0;
        for (int i = 0; i < IN_BYTES; i++) begin
            if (LEN_W'(i) < w_pc && w_ovr[i])
                w_size_ovr = 1'b1;
        end
    end

    // Opcode and the five bytes that follow it.
    for (genvar gk = 0; gk < 6; gk++) begin : g_win
        assign w_win[gk] = w_byte[IDX_W'({1'b0, w_pc} + IDX_W'(gk))];
    end

    assign w_reg      = w_win[1][5:3];
    assign w_end_addr = i_item.instr_addr + ADDR_W'(w_eff_len);
    assign w_disp1    = {w_win[4], w_win[3], w_win[2], w_win[1]};
    assign w_disp2    = {w_win[5], w_win[4], w_win[3], w_win[2]};
    assign w_rel8     = {{(ADDR_W-8){w_win[1][7]}}, w_win[1]};

    // Class, form and branch target.
    always_comb begin
        o_result.instr_class   = CLS_OTHER;
        o_result.operand_form  = FORM_NONE;
        o_result.branch_target = '0;
        o_result.target_status = ST_NOT_BRANCH;
        o_result.prefix_count  = w_pc;
        if (w_pc < w_eff_len) begin
            o_result.instr_class  = classify(w_win[0], w_win[1]);
            o_result.operand_form = form_of(w_win[0]);
            if (w_size_ovr) begin
                o_result.target_status = ST_UNSUPPORTED;
            end else if ((w_win[0] >= OP_JCC_LO && w_win[0] <= OP_JCC_HI) ||
                         (w_win[0] >= OP_LOOP_LO && w_win[0] <= OP_LOOP_HI) ||
                         w_win[0] == OP_JMP_SH) begin
                o_result.branch_target = w_end_addr + w_rel8;
                o_result.target_status = ST_RESOLVED;
            end else if (w_win[0] == OP_JMP_FAR || w_win[0] == OP_CALL_FAR) begin
                o_result.target_status = ST_UNSUPPORTED;
            end else if (w_win[0] == OP_JMP_REL || w_win[0] == OP_CALL_REL) begin
                o_result.branch_target = w_end_addr + w_disp1;
                o_result.target_status = ST_RESOLVED;
            end else if (w_win[0] == OP_TWO_BYTE && w_win[1] >= OP_JCC32_LO &&
                         w_win[1] <= OP_JCC32_HI) begin
                o_result.branch_target = w_end_addr + w_disp2;
                o_result.target_status = ST_RESOLVED;
            end else if (w_win[0] == OP_GRP5 && (w_reg == REG_CALL_N || w_reg == REG_JMP_N)) begin
                if (w_win[1][7:6] == MOD_MEM && w_win[1][2:0] == RM_DISP32) begin
                    o_result.branch_target = w_disp2 - i_image_base;
                    o_result.target_status = ST_RESOLVED;
                end else begin
                    o_result.target_status = ST_REG_INDIR;
                end
            end else if (w_win[0] == OP_GRP5 && (w_reg == REG_CALL_F || w_reg == REG_JMP_F)) begin
                o_result.target_status = ST_UNSUPPORTED;
            end else begin
                o_result.target_status = ST_NOT_BRANCH;
            end
        end
    end

endmodule

// ===== design/x86_branch_instruction_classifier.sv =====
// Classifies one delimited 32-bit x86 instruction per item and resolves its branch
// target. An item is registered on acceptance, decoded in the following cycle and
// its result is held in an output register. One item is accepted every cycle as
// long as results are taken; the figure is set by the two register stages, each
// taking a new item when empty or moving on. The output register stalls while it
// holds a result not yet taken; the item register stalls only when it is also full.
// The image base register is written through i_cfg_we and i_cfg_data and should
// only change while no item is in flight.
`include "assert_macros.svh"

module x86_branch_instruction_classifier (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [xbic_pkg::ADDR_W-1:0]      i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [xbic_pkg::LOW_W-1:0]       i_bytes_low,
    input  logic [xbic_pkg::HIGH_W-1:0]      i_bytes_high,
    input  logic [xbic_pkg::LEN_W-1:0]       i_length,
    input  logic [xbic_pkg::ADDR_W-1:0]      i_instr_addr,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [xbic_pkg::CLASS_W-1:0]     o_instr_class,
    output logic [xbic_pkg::FORM_W-1:0]      o_operand_form,
    output logic [xbic_pkg::ADDR_W-1:0]      o_branch_target,
    output logic [xbic_pkg::STATUS_W-1:0]    o_target_status,
    output logic [xbic_pkg::LEN_W-1:0]       o_prefix_count
);
    import xbic_pkg::*;

    logic              r_s1_valid;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_image_base;
    t_item             r_item;
    t_result           r_result;
    logic              n_s1_valid;
    logic              n_out_valid;
    logic [ADDR_W-1:0] n_image_base;
    logic              w_out_free;
    logic              w_in_free;
    t_result           w_result;

    // Decode of the registered item.
    xbic_decode u_decode (
        .i_item       (r_item),
        .i_image_base (r_image_base),
        .o_result     (w_result)
    );

    // Stage flow: each stage takes a new item when it is empty or moving on.
    assign w_out_free = !r_out_valid || i_ready;
    assign w_in_free  = !r_s1_valid || w_out_free;
    assign o_ready    = w_in_free;

    always_comb begin
        n_s1_valid   = w_in_free ? i_valid : r_s1_valid;
        n_out_valid  = w_out_free ? r_s1_valid : r_out_valid;
        n_image_base = i_cfg_we ? i_cfg_data : r_image_base;
    end

    // Control and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_image_base <= IMAGE_BASE_RESET;
        end else begin
            r_s1_valid   <= n_s1_valid;
            r_out_valid  <= n_out_valid;
            r_image_base <= n_image_base;
        end
    end

    // Item and result payload registers.
    always_ff @(posedge i_clk) begin
        if (i_valid && w_in_free) begin
            r_item.bytes_low  <= i_bytes_low;
            r_item.bytes_high <= i_bytes_high;
            r_item.length     <= i_length;
            r_item.instr_addr <= i_instr_addr;
        end
        if (r_s1_valid && w_out_free)
            r_result <= w_result;
    end

    assign o_valid         = r_out_valid;
    assign o_instr_class   = r_result.instr_class;
    assign o_operand_form  = r_result.operand_form;
    assign o_branch_target = r_result.branch_target;
    assign o_target_status = r_result.target_status;
    assign o_prefix_count  = r_result.prefix_count;

    // A decoded item reaches the output register on the next edge when it is free.
    `ASSERT_CLK(a_advance, i_clk, i_rst_n, (r_s1_valid && w_out_free) |=> r_out_valid, "decoded item did not advance")
    // Unresolved results carry a zero target.
    `ASSERT_CLK(a_target_zero, i_clk, i_rst_n, (r_out_valid && r_result.target_status != ST_RESOLVED) |-> (r_result.branch_target == '0), "unresolved result has a target")
    // Conditional jumps are always resolved unless a size override is present.
    `ASSERT_CLK(a_condjump, i_clk, i_rst_n, (r_out_valid && r_result.instr_class == CLS_CONDJUMP) |-> (r_result.target_status == ST_RESOLVED || r_result.target_status == ST_UNSUPPORTED), "conditional jump with bad status")
    // Both stages are empty on the edge after one that sees reset asserted.
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!r_s1_valid && !r_out_valid), "stages not empty after reset")

endmodule
